FILE: rtl/tkc_pkg.sv
// Package for the transmitter key controller.
// Holds the transfer payload types, the register set type, event and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tkc_pkg;

  // Register file geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int TIME_W     = 12;   // hour*100+minute, up to 3163 on raw fields

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_OP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_FINISH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TX_IDLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RPT_QUIET   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDENT_QUIET = 3'd7;

  // Register reset values
  localparam logic [TIME_W-1:0] OP_START_RST  = 12'd0;
  localparam logic [TIME_W-1:0] OP_FINISH_RST = 12'd2359;

  // Event codes
  localparam logic [3:0] EV_OFF         = 4'd0;
  localparam logic [3:0] EV_ON          = 4'd1;
  localparam logic [3:0] EV_STARTUP     = 4'd2;
  localparam logic [3:0] EV_CAROUSEL    = 4'd3;
  localparam logic [3:0] EV_ANNOUNCE    = 4'd4;
  localparam logic [3:0] EV_IDENT_START = 4'd5;
  localparam logic [3:0] EV_IDENT_END   = 4'd6;
  localparam logic [3:0] EV_PERIODIC    = 4'd7;

  // Status codes
  localparam logic [1:0] ST_OFF       = 2'd0;
  localparam logic [1:0] ST_ON        = 2'd1;
  localparam logic [1:0] ST_NO_CHANGE = 2'd2;

  // Time constants
  localparam logic [TIME_W-1:0] HOUR_SCALE    = 12'd100;
  localparam logic [5:0]        HALF_HOUR_END = 6'd29;
  localparam logic [5:0]        MINUTES_HOUR  = 6'd60;

  typedef struct packed {
    logic [3:0] kind;
    logic [4:0] utc_hour;
    logic [5:0] utc_minute;
    logic       input_after_ident;
  } in_item_t;

  typedef struct packed {
    logic       key_written;
    logic       key_level;
    logic [1:0] status;
    logic       quiet_now;
  } out_item_t;

  typedef struct packed {
    logic              always_operating;
    logic [TIME_W-1:0] operating_start;
    logic [TIME_W-1:0] operating_finish;
    logic              half_hour_power_save;
    logic              transmit_enabled;
    logic              transmit_when_idle;
    logic              repeat_in_quiet;
    logic              ident_in_quiet;
  } cfg_t;

endpackage

FILE: rtl/transmitter_key_controller.sv
// Top level of the transmitter key controller: input register, rule logic,
// result register and configuration registers. Depends on tkc_pkg,
// tkc_cfg_regs and tkc_rules.
//
//   port group | direction | carries
//   in_*       | in        | event item (in_item_t), valid/stall
//   out_*      | out       | key decision (out_item_t), valid/stall
//   cfg_*      | in        | register writes, index and data
//
// One item per cycle sustained while out_stall stays low. An input transfer
// passes through the input register, then rule logic into the result register;
// a stall on the result side can hold it in the input register in between.
// Reset clears both stage valids, the stored quiet/half-hour flags and the
// registers to their defaults. A stalled result holds; the input stage then
// fills and in_stall rises only while it holds an item that cannot move on.
`timescale 1ns / 1ps

module transmitter_key_controller
  import tkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  out_item_t result;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      in_take;
  logic      advance;

  tkc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tkc_rules u_rules (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Stage handshakes
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef ASSERT_OFF
  // A driven-high level always comes with a key write
  a_level_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.key_written || !out_data.key_level))
    else $error("key level high without key write");

  // Keyed-on status matches a high key write
  a_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ON) |->
      (out_data.key_written && out_data.key_level))
    else $error("status on without keying");

  // No-change status only ever with nothing driven
  a_no_change_quiet_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_NO_CHANGE) |-> !out_data.key_written)
    else $error("no-change status with key written");

  // Input stall only while the input stage holds an item
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled with nothing blocking");
`endif

endmodule

FILE: rtl/tkc_cfg_regs.sv
// Configuration register file of the transmitter key controller.
// Decodes the plain write port into the cfg_t register set. Depends on tkc_pkg.
`timescale 1ns / 1ps

module tkc_cfg_regs
  import tkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ALWAYS_OP:   cfg_nxt.always_operating     = cfg_wdata[0];
        REG_OP_START:    cfg_nxt.operating_start      = cfg_wdata[TIME_W-1:0];
        REG_OP_FINISH:   cfg_nxt.operating_finish     = cfg_wdata[TIME_W-1:0];
        REG_HALF_HOUR:   cfg_nxt.half_hour_power_save = cfg_wdata[0];
        REG_TX_ENABLED:  cfg_nxt.transmit_enabled     = cfg_wdata[0];
        REG_TX_IDLE:     cfg_nxt.transmit_when_idle   = cfg_wdata[0];
        REG_RPT_QUIET:   cfg_nxt.repeat_in_quiet      = cfg_wdata[0];
        REG_IDENT_QUIET: cfg_nxt.ident_in_quiet       = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.always_operating     <= 1'b0;
      cfg_r.operating_start      <= OP_START_RST;
      cfg_r.operating_finish     <= OP_FINISH_RST;
      cfg_r.half_hour_power_save <= 1'b0;
      cfg_r.transmit_enabled     <= 1'b1;
      cfg_r.transmit_when_idle   <= 1'b0;
      cfg_r.repeat_in_quiet      <= 1'b0;
      cfg_r.ident_in_quiet       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/tkc_rules.sv
// Keying rules of the transmitter key controller: quiet hours, half-hour
// power save, per-event decision and the stored quiet/half-hour flags.
// Depends on tkc_pkg.
`timescale 1ns / 1ps

module tkc_rules
  import tkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,      // item leaves the input stage this cycle
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic quiet_flag_r, quiet_flag_nxt;
  logic prev_quiet_r, prev_quiet_nxt;
  logic prev_half_r,  prev_half_nxt;

  logic [TIME_W-1:0] now;
  logic              in_window_q;
  logic              quiet;
  logic              sh;
  logic              idle;
  logic              wr;
  logic              lvl;
  logic [1:0]        st;

  // Time of day from the raw fields
  assign now = TIME_W'(item.utc_hour) * HOUR_SCALE + TIME_W'(item.utc_minute);

  // Quiet hours: plain window when start < finish, otherwise wraps midnight
  always_comb begin
    if (cfg.operating_start < cfg.operating_finish) begin
      in_window_q = (now < cfg.operating_start) || (now > cfg.operating_finish);
    end else begin
      in_window_q = (now < cfg.operating_start) && (now > cfg.operating_finish);
    end
  end

  assign quiet = !cfg.always_operating && in_window_q;
  assign sh    = cfg.half_hour_power_save && !quiet &&
                 (item.utc_minute > HALF_HOUR_END) && (item.utc_minute < MINUTES_HOUR);
  assign idle  = cfg.transmit_when_idle;

  // Event decision
  always_comb begin
    wr             = 1'b0;
    lvl            = 1'b0;
    st             = ST_OFF;
    quiet_flag_nxt = quiet_flag_r;
    prev_quiet_nxt = prev_quiet_r;
    prev_half_nxt  = prev_half_r;
    case (item.kind)
      EV_OFF: begin
        wr = 1'b1;
      end
      EV_ON: begin
        wr  = 1'b1;
        lvl = 1'b1;
        st  = ST_ON;
      end
      default: begin
        quiet_flag_nxt = quiet;
        if (cfg.transmit_enabled) begin
          case (item.kind)
            EV_STARTUP: begin
              wr  = 1'b1;
              lvl = !quiet;
              st  = quiet ? ST_OFF : ST_ON;
            end
            EV_CAROUSEL: begin
              wr = (quiet || sh) && idle;
            end
            EV_ANNOUNCE: begin
              if (sh || !idle || (quiet && cfg.repeat_in_quiet)) begin
                wr  = 1'b1;
                lvl = 1'b1;
                st  = ST_ON;
              end
            end
            EV_IDENT_START: begin
              if ((sh && !quiet) || (quiet && cfg.ident_in_quiet)) begin
                wr  = 1'b1;
                lvl = 1'b1;
                st  = ST_ON;
              end
            end
            EV_IDENT_END: begin
              wr = (sh || quiet) && !item.input_after_ident && !idle;
            end
            EV_PERIODIC: begin
              if (quiet == prev_quiet_r && sh == prev_half_r) begin
                st = ST_NO_CHANGE;
              end else if (quiet != prev_quiet_r) begin
                // quiet hours edge; the half-hour change waits its turn
                if (!quiet && !idle) begin
                  wr             = 1'b1;
                  lvl            = 1'b1;
                  st             = ST_ON;
                  prev_quiet_nxt = quiet;
                end else if (quiet && !item.input_after_ident) begin
                  wr             = 1'b1;
                  prev_quiet_nxt = quiet;
                end
              end else begin
                if (!sh && !quiet && !idle) begin
                  wr            = 1'b1;
                  lvl           = 1'b1;
                  st            = ST_ON;
                  prev_half_nxt = sh;
                end else if (sh && !item.input_after_ident) begin
                  wr            = 1'b1;
                  prev_half_nxt = sh;
                end
              end
            end
            default: begin
              // unused codes force the key off
              wr = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  assign result.key_written = wr;
  assign result.key_level   = lvl;
  assign result.status      = st;
  assign result.quiet_now   = quiet_flag_nxt;

  // Stored flags advance with each item taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_flag_r <= 1'b0;
      prev_quiet_r <= 1'b0;
      prev_half_r  <= 1'b0;
    end else if (fire) begin
      quiet_flag_r <= quiet_flag_nxt;
      prev_quiet_r <= prev_quiet_nxt;
      prev_half_r  <= prev_half_nxt;
    end
  end

endmodule

FILE: tb/sv/tkc_key_checker.sv
// Scoreboard for the transmitter key controller: watches the event and result channels,
// keeps its own copy of the registers and flags, predicts each key decision and compares.
// Depends on tkc_pkg.
`timescale 1ns / 1ps

module tkc_key_checker
  import tkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    awaiting
);

  // Shadow registers and flags
  cfg_t      regs;
  logic      quiet_st;
  logic      last_quiet;
  logic      last_second_half;
  out_item_t key_queue[$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  // Quiet hours from the operating window; start >= finish wraps midnight
  function automatic logic window_quiet(input int unsigned now);
    if (regs.always_operating) return 1'b0;
    if (regs.operating_start < regs.operating_finish)
      return (now < regs.operating_start) || (now > regs.operating_finish);
    return (now < regs.operating_start) && (now > regs.operating_finish);
  endfunction

  function automatic out_item_t drive_key(input logic lvl);
    out_item_t r;
    r             = '0;
    r.key_written = 1'b1;
    r.key_level   = lvl;
    r.status      = lvl ? ST_ON : ST_OFF;
    return r;
  endfunction

  // Key decision for one event; updates the stored flags as the block does
  function automatic out_item_t predict_key(input in_item_t ev);
    out_item_t   r;
    int unsigned now;
    logic        sh;
    logic        idle;
    r = '0;
    if (ev.kind == EV_OFF) begin
      r = drive_key(1'b0);
    end else if (ev.kind == EV_ON) begin
      r = drive_key(1'b1);
    end else begin
      now      = int'(ev.utc_hour) * int'(HOUR_SCALE) + int'(ev.utc_minute);
      quiet_st = window_quiet(now);
      sh       = regs.half_hour_power_save && !quiet_st &&
                 (ev.utc_minute > HALF_HOUR_END) && (ev.utc_minute < MINUTES_HOUR);
      idle     = regs.transmit_when_idle;
      if (regs.transmit_enabled) begin
        case (ev.kind)
          EV_STARTUP: begin
            r = drive_key(!quiet_st);
          end
          EV_CAROUSEL: begin
            if ((quiet_st || sh) && idle) r = drive_key(1'b0);
          end
          EV_ANNOUNCE: begin
            if (sh || !idle || (quiet_st && regs.repeat_in_quiet)) r = drive_key(1'b1);
          end
          EV_IDENT_START: begin
            if ((sh && !quiet_st) || (quiet_st && regs.ident_in_quiet)) r = drive_key(1'b1);
          end
          EV_IDENT_END: begin
            if ((sh || quiet_st) && !ev.input_after_ident && !idle) r = drive_key(1'b0);
          end
          EV_PERIODIC: begin
            // flags only move when the key is actually driven
            if (quiet_st == last_quiet && sh == last_second_half) begin
              r.status = ST_NO_CHANGE;
            end else if (quiet_st != last_quiet) begin
              if (!quiet_st && !idle) begin
                r = drive_key(1'b1);
                last_quiet = quiet_st;
              end else if (quiet_st && !ev.input_after_ident) begin
                r = drive_key(1'b0);
                last_quiet = quiet_st;
              end
            end else begin
              if (!sh && !quiet_st && !idle) begin
                r = drive_key(1'b1);
                last_second_half = sh;
              end else if (sh && !ev.input_after_ident) begin
                r = drive_key(1'b0);
                last_second_half = sh;
              end
            end
          end
          default: begin
            r = drive_key(1'b0);
          end
        endcase
      end
    end
    r.quiet_now = quiet_st;
    return r;
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Results are checked before the new transfer is queued
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      regs.always_operating     = 1'b0;
      regs.operating_start      = OP_START_RST;
      regs.operating_finish     = OP_FINISH_RST;
      regs.half_hour_power_save = 1'b0;
      regs.transmit_enabled     = 1'b1;
      regs.transmit_when_idle   = 1'b0;
      regs.repeat_in_quiet      = 1'b0;
      regs.ident_in_quiet       = 1'b0;
      quiet_st         = 1'b0;
      last_quiet       = 1'b0;
      last_second_half = 1'b0;
      key_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (key_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, out_data);
        end else begin
          want = key_queue.pop_front();
          if (out_data.key_written !== want.key_written)
            flag_field("key_written", want.key_written, out_data.key_written);
          if (out_data.key_level !== want.key_level)
            flag_field("key_level", want.key_level, out_data.key_level);
          if (out_data.status !== want.status)
            flag_field("status", want.status, out_data.status);
          if (out_data.quiet_now !== want.quiet_now)
            flag_field("quiet_now", want.quiet_now, out_data.quiet_now);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALWAYS_OP:   regs.always_operating     = cfg_wdata[0];
          REG_OP_START:    regs.operating_start      = cfg_wdata;
          REG_OP_FINISH:   regs.operating_finish     = cfg_wdata;
          REG_HALF_HOUR:   regs.half_hour_power_save = cfg_wdata[0];
          REG_TX_ENABLED:  regs.transmit_enabled     = cfg_wdata[0];
          REG_TX_IDLE:     regs.transmit_when_idle   = cfg_wdata[0];
          REG_RPT_QUIET:   regs.repeat_in_quiet      = cfg_wdata[0];
          REG_IDENT_QUIET: regs.ident_in_quiet       = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) key_queue.push_back(predict_key(in_data));
    end
    awaiting = key_queue.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the transmitter key controller: clock, reset, register setup,
// event stimulus and result back-pressure, and the final verdict.
// Depends on tkc_pkg, transmitter_key_controller and tkc_key_checker.
`timescale 1ns / 1ps

module tb_top;
  import tkc_pkg::*;

  localparam int KIND_MAX     = 15;
  localparam int LONG_HOLD    = 60;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 135;
  localparam int LATE_HOUR    = 23;
  localparam int LATE_MINUTE  = 59;
  localparam int RAW_HOUR     = 31;
  localparam int RAW_MINUTE   = 63;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    awaiting;

  bit          steady;        // no idling on either side
  bit          hold_pending;  // receiver to hold off for a long stretch
  int unsigned win_start;
  int unsigned win_finish;

  transmitter_key_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tkc_key_checker key_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("** transmitter_key_controller: FAILED **");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic in_item_t event_at(input logic [3:0] kind, input int hour,
                                        input int minute, input bit after_ident);
    in_item_t ev;
    ev.kind              = kind;
    ev.utc_hour          = 5'(hour);
    ev.utc_minute        = 6'(minute);
    ev.input_after_ident = after_ident;
    return ev;
  endfunction

  // Random event; times cluster round the window edges to flip the quiet flag
  function automatic in_item_t random_event();
    int unsigned pick;
    int          edge_hhmm;
    int          hour;
    int          minute;
    pick = $urandom_range(0, 99);
    if (pick < 10) hour = $urandom_range(EV_OFF, EV_ON);
    else if (pick < 85) hour = $urandom_range(EV_STARTUP, EV_PERIODIC);
    else hour = $urandom_range(int'(EV_PERIODIC) + 1, KIND_MAX);
    pick = hour;
    case ($urandom_range(0, 9))
      0: begin
        hour   = $urandom_range(0, RAW_HOUR);
        minute = $urandom_range(0, RAW_MINUTE);
      end
      1, 2, 3: begin
        edge_hhmm = int'(($urandom_range(0, 1) ? win_start : win_finish) +
                         $urandom_range(0, 2) - 1);
        if (edge_hhmm < 0) edge_hhmm = 0;
        hour   = edge_hhmm / int'(HOUR_SCALE);
        minute = edge_hhmm % int'(HOUR_SCALE);
      end
      default: begin
        hour   = $urandom_range(0, LATE_HOUR);
        minute = $urandom_range(0, LATE_MINUTE);
      end
    endcase
    return event_at(4'(pick), hour, minute, 1'($urandom_range(0, 1)));
  endfunction

  function automatic int unsigned random_hhmm();
    return $urandom_range(0, LATE_HOUR) * int'(HOUR_SCALE) + $urandom_range(0, LATE_MINUTE);
  endfunction

  // One event transfer, then perhaps an idle gap
  task automatic send_event(input in_item_t ev);
    int unsigned span;
    @(negedge clk);
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!steady && $urandom_range(0, 3) == 0) begin
      span = idle_span();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (span - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected result is in
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Full register set per phase: window extremes first, random windows after
  task automatic program_phase(input int p);
    case (p)
      0: begin win_start = int'(OP_START_RST);  win_finish = int'(OP_FINISH_RST); end
      1: begin win_start = 0;                   win_finish = 0;                   end
      2: begin win_start = int'(OP_FINISH_RST); win_finish = 0;                   end
      3: begin win_start = int'(OP_FINISH_RST); win_finish = int'(OP_FINISH_RST); end
      4: begin win_start = 2200;                win_finish = 600;                 end
      5: begin win_start = 600;                 win_finish = 2200;                end
      default: begin win_start = random_hhmm(); win_finish = random_hhmm(); end
    endcase
    set_reg(REG_ALWAYS_OP, ($urandom_range(0, 3) == 0) ? 1 : 0);
    set_reg(REG_OP_START, win_start);
    set_reg(REG_OP_FINISH, win_finish);
    set_reg(REG_HALF_HOUR, $urandom_range(0, 1));
    set_reg(REG_TX_ENABLED, ((p == 0) || ($urandom_range(0, 4) != 0)) ? 1 : 0);
    set_reg(REG_TX_IDLE, $urandom_range(0, 1));
    set_reg(REG_RPT_QUIET, $urandom_range(0, 1));
    set_reg(REG_IDENT_QUIET, $urandom_range(0, 1));
    end_writes();
  endtask

  // Result side back-pressure, including the one long hold-off
  initial begin : sink
    int unsigned span;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_pending = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        span = idle_span();
        out_stall <= 1'b1;
        repeat (span - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin : source
    int p;
    int n;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    steady       = 1'b0;
    hold_pending = 1'b0;
    win_start    = int'(OP_START_RST);
    win_finish   = int'(OP_FINISH_RST);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: forced keying, start-up, each rule, out of range times
    send_event(event_at(EV_OFF, RAW_HOUR, RAW_MINUTE, 1'b1));
    send_event(event_at(EV_ON, 0, 0, 1'b0));
    send_event(event_at(EV_STARTUP, 0, 0, 1'b0));
    send_event(event_at(EV_STARTUP, RAW_HOUR, RAW_MINUTE, 1'b0));
    send_event(event_at(EV_CAROUSEL, 12, 30, 1'b0));
    send_event(event_at(EV_ANNOUNCE, 12, 30, 1'b0));
    send_event(event_at(EV_IDENT_START, 12, 30, 1'b0));
    send_event(event_at(EV_IDENT_END, 12, 30, 1'b0));
    send_event(event_at(EV_PERIODIC, 12, 0, 1'b0));
    send_event(event_at(EV_PERIODIC, 24, 0, 1'b0));
    send_event(event_at(EV_PERIODIC, 24, 0, 1'b1));
    send_event(event_at(EV_PERIODIC, 12, 0, 1'b1));
    send_event(event_at(EV_PERIODIC + 4'd1, 6, 15, 1'b0));
    send_event(event_at(4'(KIND_MAX), LATE_HOUR, LATE_MINUTE, 1'b1));
    send_event(event_at(EV_IDENT_END, 24, 10, 1'b0));
    settle();

    // Power save, carrier drop when idle, keying allowed in quiet hours
    set_reg(REG_HALF_HOUR, 1);
    set_reg(REG_TX_IDLE, 1);
    set_reg(REG_RPT_QUIET, 1);
    set_reg(REG_IDENT_QUIET, 1);
    end_writes();
    send_event(event_at(EV_CAROUSEL, 10, 45, 1'b0));
    send_event(event_at(EV_CAROUSEL, 10, 15, 1'b0));
    send_event(event_at(EV_ANNOUNCE, 25, 0, 1'b0));
    send_event(event_at(EV_IDENT_START, 10, 45, 1'b0));
    send_event(event_at(EV_IDENT_START, 25, 0, 1'b0));
    send_event(event_at(EV_IDENT_END, 10, 45, 1'b0));
    send_event(event_at(EV_PERIODIC, 10, 45, 1'b1));
    send_event(event_at(EV_PERIODIC, 10, 45, 1'b0));
    send_event(event_at(EV_PERIODIC, 10, 10, 1'b1));
    settle();

    // Transmission disabled: only forced keying acts
    set_reg(REG_TX_ENABLED, 0);
    end_writes();
    send_event(event_at(EV_STARTUP, 25, 0, 1'b0));
    send_event(event_at(EV_PERIODIC, 0, 0, 1'b0));
    send_event(event_at(4'(KIND_MAX), 0, 0, 1'b0));
    send_event(event_at(EV_ON, 0, 0, 1'b0));
    settle();

    // Random phases; two without idling, one of them with the long receiver hold-off
    for (p = 0; p < PHASES; p++) begin
      program_phase(p);
      steady       = (p == 1) || (p == 2);
      hold_pending = (p == 2);
      for (n = 0; n < PHASE_ITEMS; n++) send_event(random_event());
      settle();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("** transmitter_key_controller: PASSED **");
    end else begin
      $display("** transmitter_key_controller: FAILED **");
    end
    $finish;
  end

endmodule
